>>> rtl/assert_macros.svh
// Assertion macros for the port checks in rtl/gllm_checker.sv.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, active during reset as well.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/gllm_pkg.sv
// Shared types, sizes and the Gaussian weight table for the line library matcher.
// No dependencies.
`default_nettype none

package gllm_pkg;

  localparam int LIBRARY_LINES = 64;
  localparam int ISOTOPES      = 64;
  localparam int PEAK_SLOTS    = 16;
  localparam int WTAB_SIZE     = 256;
  localparam int DEFAULT_WIDTH = 80;

  localparam int LIB_AW    = (LIBRARY_LINES > 1) ? $clog2(LIBRARY_LINES) : 1;
  localparam int LCNT_W    = $clog2(LIBRARY_LINES + 1);
  localparam int PEAK_AW   = (PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1;
  localparam int PCNT_W    = $clog2(PEAK_SLOTS + 1);
  localparam int RES_DEPTH = (LIBRARY_LINES > ISOTOPES) ? LIBRARY_LINES : ISOTOPES;
  localparam int RES_AW    = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int RCNT_W    = $clog2(RES_DEPTH + 1);
  localparam int SCAN_W    = $clog2(RES_DEPTH + 1);

  localparam int WIN_W   = 14;
  localparam int TIDX_W  = $clog2(WTAB_SIZE);
  localparam int Q_W     = TIDX_W + 1;
  localparam int NUM_W   = WIN_W + TIDX_W + 2;
  localparam int PROD_W  = 32;
  localparam int SCORE_W = 44;
  localparam int CNT_W   = 13;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    MODE_LIB_WR     = 2'd0,
    MODE_PEAK_ADD   = 2'd1,
    MODE_LINE_MATCH = 2'd2,
    MODE_IDENTIFY   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_LINE = 2'd1,
    KIND_CAND = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        clear_first;
    logic [5:0]  isotope_id;
    logic [15:0] energy;
    logic [15:0] intensity;
    logic [11:0] width;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               status;
    logic [5:0]         match_isotope;
    logic [15:0]        line_energy;
    logic [15:0]        distance;
    logic [15:0]        line_intensity;
    logic [SCORE_W-1:0] score;
    logic [CNT_W-1:0]   match_count;
    logic               last;
  } out_item_t;

  // Classified command as it sits in the queue
  typedef struct packed {
    mode_t            mode;
    logic             clear_first;
    logic [5:0]       isotope_id;
    logic [15:0]      energy;
    logic [15:0]      intensity;
    logic [WIN_W-1:0] win;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic [5:0]  iso;
    logic [15:0] energy;
    logic [15:0] intensity;
  } lib_t;

  typedef struct packed {
    logic [CNT_W-1:0]   cnt;
    logic [SCORE_W-1:0] score;
    logic [5:0]         iso;
    logic [15:0]        energy;
    logic [15:0]        delta;
    logic [15:0]        intensity;
  } res_t;

  typedef logic [15:0] wtab_t [WTAB_SIZE];

  localparam longint unsigned S2      = 64'(WTAB_SIZE) * 64'(WTAB_SIZE);
  localparam longint unsigned LN2_Q30 = 64'd744261118;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  // exp(-y) by series, scaled by 2^-n; evaluated at elaboration only
  function automatic logic [15:0] weight_entry(input int unsigned idx);
    longint unsigned e, n, r, f, y, term, v;
    longint          sum;
    int              k;
    e = 64'd36 * 64'(idx) * 64'(idx);
    n = e / S2;
    r = e % S2;
    if (n >= 64'd40) return 16'd0;
    f = (r << 30) / S2;
    y = (f * LN2_Q30) >> 30;
    term = ONE_Q30;
    sum = longint'(ONE_Q30);
    for (k = 1; k <= 16; k++) begin
      term = ((term * y) >> 30) / 64'(k);
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    v = ($unsigned(sum) + (64'd1 << (13 + n))) >> (14 + n);
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic wtab_t build_wtab();
    wtab_t t;
    for (int i = 0; i < WTAB_SIZE; i++) t[i] = weight_entry(i);
    return t;
  endfunction

  localparam wtab_t WTAB = build_wtab();

endpackage

`default_nettype wire

>>> rtl/gllm_div.sv
// Restoring divider, one quotient bit per cycle, for the weight table index.
// Depends on gllm_pkg.
`default_nettype none

module gllm_div import gllm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [WIN_W:0]   den,
  output logic                  done,
  output logic [Q_W-1:0]        quot
);

  localparam int SW = $clog2(Q_W) + 1;

  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] dsh_r;
  logic [Q_W-1:0]   q_r;
  logic [SW-1:0]    step_r;
  logic             run_r;
  logic             done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && !start && (step_r == '0);
      if (start) begin
        run_r  <= 1'b1;
        step_r <= SW'(Q_W - 1);
        rem_r  <= num;
        dsh_r  <= NUM_W'(den) << (Q_W - 1);
        q_r    <= '0;
      end else if (run_r) begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[Q_W-2:0], 1'b1};
        end else begin
          q_r <= {q_r[Q_W-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
        if (step_r == '0) begin
          run_r <= 1'b0;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

>>> rtl/gllm_front.sv
// Front end: takes input items, resolves the match window, queues up to two commands.
// Depends on gllm_pkg.
`default_nettype none

module gllm_front import gllm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_data,
  input  wire logic     q_pop,
  output q_head_t       q_head
);

  cmd_t       slot_r [2];
  logic       rd_ptr_r;
  logic       wr_ptr_r;
  logic [1:0] cnt_r;
  logic       accept;
  logic [11:0] w_eff;
  cmd_t       cmd_in;

  assign busy   = (cnt_r == 2'd2);
  assign accept = start && !busy;

  always_comb begin
    w_eff = (in_data.width == 12'd0) ? 12'(DEFAULT_WIDTH) : in_data.width;
    cmd_in.mode        = mode_t'(in_data.mode);
    cmd_in.clear_first = in_data.clear_first;
    cmd_in.isotope_id  = in_data.isotope_id;
    cmd_in.energy      = in_data.energy;
    cmd_in.intensity   = in_data.intensity;
    // window is three widths
    cmd_in.win         = WIN_W'(w_eff) + WIN_W'({w_eff, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (accept) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      unique case ({accept, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) slot_r[wr_ptr_r] <= cmd_in;
  end

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.cmd   = slot_r[rd_ptr_r];

endmodule

`default_nettype wire

>>> rtl/gllm_back.sv
// Back end: library and peak stores, line scoring, per-isotope sums, selection sort.
// Depends on gllm_pkg and gllm_div.
`default_nettype none

module gllm_back import gllm_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_head_t q_head,
  output logic         q_pop,
  output logic         out_strobe,
  output out_item_t    out_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LRD, ST_LCHK, ST_PCHK, ST_DIV, ST_MUL, ST_ACC, ST_SEL, ST_SCAN, ST_EMIT
  } state_t;

  state_t                state_r;
  cmd_t                  cmd_r;
  logic [LCNT_W-1:0]     lib_cnt_r;
  logic [PCNT_W-1:0]     peak_cnt_r;
  logic [15:0]           peak_r [PEAK_SLOTS];
  logic [LCNT_W-1:0]     i_r;
  logic [PEAK_AW-1:0]    p_r;
  logic [15:0]           d_r;
  logic [15:0]           weight_r;
  logic [PROD_W-1:0]     prod_r;
  logic [RES_DEPTH-1:0]  live_r;
  logic [RCNT_W-1:0]     live_cnt_r;
  logic [SCAN_W-1:0]     j_r;
  res_t                  best_r;
  logic [RES_AW-1:0]     best_idx_r;
  logic                  have_best_r;
  logic                  out_strobe_r;
  out_item_t             out_r;

  lib_t                  lib_mem [LIBRARY_LINES];
  lib_t                  lib_rd_r;
  res_t                  res_mem [RES_DEPTH];
  res_t                  res_rd_r;

  // combinational
  cmd_t               hcmd;
  logic [LCNT_W-1:0]  lib_fill;
  logic [PCNT_W-1:0]  peak_fill;
  logic               lib_we;
  logic               peak_we;
  out_item_t          ack_d;
  out_item_t          none_d;
  logic               out_strobe_nxt;
  logic [15:0]        d_q;
  logic [15:0]        d_p;
  logic [15:0]        pe;
  logic [15:0]        d_sel;
  logic               hit_q;
  logic               hit_p;
  logic               div_go;
  logic [NUM_W-1:0]   div_num;
  logic [WIN_W:0]     div_den;
  logic               div_done;
  logic [Q_W-1:0]     div_quot;
  logic [TIDX_W-1:0]  tidx;
  logic               last_peak;
  logic               iso_ok;
  logic [RES_AW-1:0]  iso_a;
  logic [RES_AW-1:0]  res_ra;
  logic [RES_AW-1:0]  res_wa;
  logic               res_we;
  res_t               res_wd;
  res_t               old_e;
  logic [RES_AW-1:0]  cmp_idx;
  logic               take;

  assign hcmd = q_head.cmd;
  assign q_pop = (state_r == ST_IDLE) && q_head.valid;

  always_comb begin
    lib_fill  = hcmd.clear_first ? '0 : lib_cnt_r;
    peak_fill = hcmd.clear_first ? '0 : peak_cnt_r;
    lib_we    = q_pop && (hcmd.mode == MODE_LIB_WR) && (lib_fill < LCNT_W'(LIBRARY_LINES));
    peak_we   = q_pop && (hcmd.mode == MODE_PEAK_ADD) && (peak_fill < PCNT_W'(PEAK_SLOTS));

    ack_d        = '0;
    ack_d.kind   = KIND_ACK;
    ack_d.status = (lib_we || peak_we) ? STATUS_OK : STATUS_FULL;
    ack_d.last   = 1'b1;

    none_d      = '0;
    none_d.kind = KIND_NONE;
    none_d.last = 1'b1;

    out_strobe_nxt = (q_pop && ((hcmd.mode == MODE_LIB_WR) || (hcmd.mode == MODE_PEAK_ADD))) ||
                     ((state_r == ST_SEL) && (live_cnt_r == '0)) ||
                     (state_r == ST_EMIT);

    d_q   = (lib_rd_r.energy > cmd_r.energy) ? lib_rd_r.energy - cmd_r.energy
                                             : cmd_r.energy - lib_rd_r.energy;
    pe    = peak_r[p_r];
    d_p   = (lib_rd_r.energy > pe) ? lib_rd_r.energy - pe : pe - lib_rd_r.energy;
    hit_q = (d_q <= 16'(cmd_r.win));
    hit_p = (d_p <= 16'(cmd_r.win));
    d_sel = (state_r == ST_PCHK) ? d_p : d_q;

    div_go  = ((state_r == ST_LCHK) && (cmd_r.mode == MODE_LINE_MATCH) && hit_q) ||
              ((state_r == ST_PCHK) && hit_p);
    div_num = (NUM_W'(d_sel[WIN_W-1:0]) << (TIDX_W + 1)) + NUM_W'(cmd_r.win);
    div_den = (WIN_W + 1)'(cmd_r.win) << 1;

    tidx = (div_quot > Q_W'(WTAB_SIZE - 1)) ? TIDX_W'(WTAB_SIZE - 1) : div_quot[TIDX_W-1:0];

    last_peak = ((PCNT_W'(p_r) + PCNT_W'(1)) == peak_cnt_r);
    iso_ok    = ({1'b0, lib_rd_r.iso} < 7'(ISOTOPES));
    iso_a     = RES_AW'(lib_rd_r.iso);
    res_ra    = (state_r == ST_SCAN) ? j_r[RES_AW-1:0] : iso_a;

    old_e  = live_r[iso_a] ? res_rd_r : '0;
    res_we = (state_r == ST_ACC);
    if (cmd_r.mode == MODE_LINE_MATCH) begin
      res_wa           = live_cnt_r[RES_AW-1:0];
      res_wd.cnt       = '0;
      res_wd.score     = SCORE_W'(prod_r);
      res_wd.iso       = lib_rd_r.iso;
      res_wd.energy    = lib_rd_r.energy;
      res_wd.delta     = d_r;
      res_wd.intensity = lib_rd_r.intensity;
    end else begin
      res_wa           = iso_a;
      res_wd.cnt       = old_e.cnt + CNT_W'(1);
      res_wd.score     = old_e.score + SCORE_W'(prod_r);
      res_wd.iso       = lib_rd_r.iso;
      res_wd.energy    = '0;
      res_wd.delta     = '0;
      res_wd.intensity = '0;
    end

    cmp_idx = RES_AW'(j_r - SCAN_W'(1));
    // strict greater keeps the lower index on ties
    take = (j_r != '0) && live_r[cmp_idx] &&
           (!have_best_r || ({res_rd_r.cnt, res_rd_r.score} > {best_r.cnt, best_r.score}));
  end

  gllm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (lib_we) begin
      lib_mem[lib_fill[LIB_AW-1:0]].iso       <= hcmd.isotope_id;
      lib_mem[lib_fill[LIB_AW-1:0]].energy    <= hcmd.energy;
      lib_mem[lib_fill[LIB_AW-1:0]].intensity <= hcmd.intensity;
    end
    lib_rd_r <= lib_mem[i_r[LIB_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    res_rd_r <= res_mem[res_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      lib_cnt_r    <= '0;
      peak_cnt_r   <= '0;
      live_r       <= '0;
      live_cnt_r   <= '0;
      have_best_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (q_head.valid) begin
            cmd_r <= hcmd;
            unique case (hcmd.mode)
              MODE_LIB_WR: begin
                out_r <= ack_d;
                if (lib_we) lib_cnt_r <= lib_fill + LCNT_W'(1);
                else lib_cnt_r <= lib_fill;
              end
              MODE_PEAK_ADD: begin
                out_r <= ack_d;
                if (peak_we) begin
                  peak_r[peak_fill[PEAK_AW-1:0]] <= hcmd.energy;
                  peak_cnt_r <= peak_fill + PCNT_W'(1);
                end else begin
                  peak_cnt_r <= peak_fill;
                end
              end
              default: begin
                live_r     <= '0;
                live_cnt_r <= '0;
                i_r        <= '0;
                state_r    <= ST_LRD;
              end
            endcase
          end
        end
        ST_LRD: begin
          if (i_r >= lib_cnt_r) state_r <= ST_SEL;
          else state_r <= ST_LCHK;
        end
        ST_LCHK: begin
          if (cmd_r.mode == MODE_LINE_MATCH) begin
            if (hit_q) begin
              d_r     <= d_q;
              state_r <= ST_DIV;
            end else begin
              i_r     <= i_r + LCNT_W'(1);
              state_r <= ST_LRD;
            end
          end else if (iso_ok && (peak_cnt_r != '0)) begin
            p_r     <= '0;
            state_r <= ST_PCHK;
          end else begin
            i_r     <= i_r + LCNT_W'(1);
            state_r <= ST_LRD;
          end
        end
        ST_PCHK: begin
          if (hit_p) begin
            d_r     <= d_p;
            state_r <= ST_DIV;
          end else if (last_peak) begin
            i_r     <= i_r + LCNT_W'(1);
            state_r <= ST_LRD;
          end else begin
            p_r <= p_r + PEAK_AW'(1);
          end
        end
        ST_DIV: begin
          if (div_done) begin
            weight_r <= WTAB[tidx];
            state_r  <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= lib_rd_r.intensity * weight_r;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          live_r[res_wa] <= 1'b1;
          if (!live_r[res_wa]) live_cnt_r <= live_cnt_r + RCNT_W'(1);
          if ((cmd_r.mode == MODE_LINE_MATCH) || last_peak) begin
            i_r     <= i_r + LCNT_W'(1);
            state_r <= ST_LRD;
          end else begin
            p_r     <= p_r + PEAK_AW'(1);
            state_r <= ST_PCHK;
          end
        end
        ST_SEL: begin
          j_r         <= '0;
          have_best_r <= 1'b0;
          if (live_cnt_r == '0) begin
            out_r   <= none_d;
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (take) begin
            best_r      <= res_rd_r;
            best_idx_r  <= cmp_idx;
            have_best_r <= 1'b1;
          end
          if (j_r == SCAN_W'(RES_DEPTH)) state_r <= ST_EMIT;
          else j_r <= j_r + SCAN_W'(1);
        end
        ST_EMIT: begin
          out_r.kind           <= (cmd_r.mode == MODE_LINE_MATCH) ? KIND_LINE : KIND_CAND;
          out_r.status         <= STATUS_OK;
          out_r.match_isotope  <= best_r.iso;
          out_r.line_energy    <= best_r.energy;
          out_r.distance       <= best_r.delta;
          out_r.line_intensity <= best_r.intensity;
          out_r.score          <= best_r.score;
          out_r.match_count    <= best_r.cnt;
          out_r.last           <= (live_cnt_r == RCNT_W'(1));
          live_r[best_idx_r]   <= 1'b0;
          live_cnt_r           <= live_cnt_r - RCNT_W'(1);
          j_r                  <= '0;
          have_best_r          <= 1'b0;
          if (live_cnt_r == RCNT_W'(1)) state_r <= ST_IDLE;
          else state_r <= ST_SCAN;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

`default_nettype wire

>>> rtl/gamma_line_library_match_core.sv
// Top level of the gamma line library matcher: front end queue plus scoring back end.
// Depends on gllm_pkg, gllm_front, gllm_back.
//
// Usage:
//   Input: drive in_data and raise start; the item transfers on a clock edge where
//   start is high and busy is low. Two items can wait in the command queue.
//   Output: each result appears on out_data for one cycle with out_strobe high;
//   out_data.last marks the final result of an item. The receiver cannot stall.
// Sequence:
//   Library or peak write: the back end pops the command when idle and registers the ack.
//   Line match: each library line is read and checked against the window; a line inside
//   it goes through the index divider (one quotient bit per cycle), then table and
//   multiply; a selection scan over the result store precedes each emitted result.
//   Identify: each line is checked against every peak, and each pair inside the window
//   goes through divider, table and multiply; a selection scan precedes each isotope.
//   A query with no hits ends with one none-found result after the scan of the library.
// Reset: synchronous, active low; library and peak counts go to zero, the queue
//   empties. Stored lines and peaks keep no value until written.
`default_nettype none

module gamma_line_library_match_core import gllm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_data,
  output logic          out_strobe,
  output out_item_t     out_data
);

  q_head_t q_head;
  logic    q_pop;

  gllm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_pop   (q_pop),
    .q_head  (q_head)
  );

  gllm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/gllm_checker.sv
// Port-level checks on the matcher top level, attached by bind.
// Depends on gllm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gllm_port_checks import gllm_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_strobe,
  input wire out_item_t out_data
);

  `ASSERT_NEXT(a_rst_quiet, !rst_n, !out_strobe && !busy)
  `ASSERT_IMPL(a_ack_last, out_strobe && (out_data.kind == KIND_ACK), out_data.last)
  `ASSERT_IMPL(a_none_last, out_strobe && (out_data.kind == KIND_NONE), out_data.last)
  `ASSERT_IMPL(a_line_nocount, out_strobe && (out_data.kind == KIND_LINE), out_data.match_count == '0)
  `ASSERT_IMPL(a_status_ack, out_strobe && (out_data.kind != KIND_ACK), out_data.status == STATUS_OK)

endmodule

bind gamma_line_library_match_core gllm_port_checks u_gllm_port_checks (.*);

`default_nettype wire

>>> dv/gllm_checker.sv
// Checker for gamma_line_library_match_core: watches the command and result ports,
// predicts every result and compares it field by field. Depends on gllm_pkg.
`timescale 1ns / 100ps

module gllm_checker import gllm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_data,
  input  logic      out_strobe,
  input  out_item_t out_data,
  output int        errors,
  output int        pending
);

  logic [15:0] gauss_lut [WTAB_SIZE];
  lib_t        lines [LIBRARY_LINES];
  int          line_cnt;
  logic [15:0] peaks [PEAK_SLOTS];
  int          peak_cnt;
  out_item_t   pending_results [$];

  // Q0.16 value of 2^(-36 t^2), t = idx/S, by a 17-term series for exp(-frac*ln2)
  function automatic logic [15:0] gauss_point(int unsigned idx);
    longint unsigned sq, whole, part, fr, yv, t, v;
    longint          acc;
    sq = 64'd36 * idx * idx;
    whole = sq / (WTAB_SIZE * WTAB_SIZE);
    part = sq % (WTAB_SIZE * WTAB_SIZE);
    if (whole >= 40) return 16'd0;
    fr = (part << 30) / (WTAB_SIZE * WTAB_SIZE);
    yv = (fr * 64'd744261118) >> 30;
    t = 64'd1 << 30;
    acc = longint'(64'd1 << 30);
    for (int k = 1; k <= 16; k++) begin
      t = ((t * yv) >> 30) / k;
      if (k % 2 == 1) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    v = (64'(acc) + (64'd1 << (13 + whole))) >> (14 + whole);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  initial begin
    for (int i = 0; i < WTAB_SIZE; i++) gauss_lut[i] = gauss_point(i);
  end

  function automatic longint unsigned gauss_weight(longint unsigned d, longint unsigned w3);
    longint unsigned idx;
    idx = (2 * d * WTAB_SIZE + w3) / (2 * w3);
    if (idx > WTAB_SIZE - 1) idx = WTAB_SIZE - 1;
    return gauss_lut[idx];
  endfunction

  function automatic out_item_t blank(kind_t k);
    out_item_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  // append one expected result at the tail
  task automatic queue_result(out_item_t r);
    pending_results = {pending_results, r};
  endtask

  task automatic predict_results(in_item_t c);
    longint unsigned w3, d, sc;
    longint unsigned key [64];
    int              tag [64];
    longint unsigned dst [64];
    longint unsigned iso_cnt [ISOTOPES];
    longint unsigned iso_sum [ISOTOPES];
    int              n, j;
    out_item_t       r;
    n = 0;
    if (c.mode == MODE_LIB_WR || c.mode == MODE_PEAK_ADD) begin
      r = blank(KIND_ACK);
      r.last = 1'b1;
      if (c.mode == MODE_LIB_WR) begin
        if (c.clear_first) line_cnt = 0;
        if (line_cnt < LIBRARY_LINES) begin
          lines[line_cnt] = '{iso: c.isotope_id, energy: c.energy, intensity: c.intensity};
          line_cnt++;
        end else r.status = STATUS_FULL;
      end else begin
        if (c.clear_first) peak_cnt = 0;
        if (peak_cnt < PEAK_SLOTS) begin
          peaks[peak_cnt] = c.energy;
          peak_cnt++;
        end else r.status = STATUS_FULL;
      end
      queue_result(r);
      return;
    end
    w3 = 3 * ((c.width == 0) ? DEFAULT_WIDTH : c.width);
    if (c.mode == MODE_LINE_MATCH) begin
      for (int i = 0; i < line_cnt; i++) begin
        d = (lines[i].energy > c.energy) ? lines[i].energy - c.energy
                                         : c.energy - lines[i].energy;
        if (d > w3) continue;
        sc = lines[i].intensity * gauss_weight(d, w3);
        j = n;
        // stable insertion: equal scores keep library order
        while (j > 0 && key[j-1] < sc) begin
          key[j] = key[j-1]; tag[j] = tag[j-1]; dst[j] = dst[j-1];
          j--;
        end
        key[j] = sc; tag[j] = i; dst[j] = d;
        n++;
      end
      for (int k = 0; k < n; k++) begin
        r = blank(KIND_LINE);
        r.match_isotope = lines[tag[k]].iso;
        r.line_energy = lines[tag[k]].energy;
        r.distance = dst[k][15:0];
        r.line_intensity = lines[tag[k]].intensity;
        r.score = key[k][SCORE_W-1:0];
        r.last = (k == n - 1);
        queue_result(r);
      end
    end else begin
      for (int i = 0; i < ISOTOPES; i++) begin
        iso_cnt[i] = 0;
        iso_sum[i] = 0;
      end
      for (int i = 0; i < line_cnt; i++) begin
        if (lines[i].iso >= ISOTOPES) continue;
        for (int p = 0; p < peak_cnt; p++) begin
          d = (lines[i].energy > peaks[p]) ? lines[i].energy - peaks[p]
                                           : peaks[p] - lines[i].energy;
          if (d > w3) continue;
          iso_cnt[lines[i].iso]++;
          iso_sum[lines[i].iso] += lines[i].intensity * gauss_weight(d, w3);
        end
      end
      for (int i = 0; i < ISOTOPES; i++) begin
        if (iso_cnt[i] == 0) continue;
        j = n;
        while (j > 0 && (dst[j-1] < iso_cnt[i] ||
               (dst[j-1] == iso_cnt[i] && key[j-1] < iso_sum[i]))) begin
          key[j] = key[j-1]; tag[j] = tag[j-1]; dst[j] = dst[j-1];
          j--;
        end
        key[j] = iso_sum[i]; tag[j] = i; dst[j] = iso_cnt[i];
        n++;
      end
      for (int k = 0; k < n; k++) begin
        r = blank(KIND_CAND);
        r.match_isotope = tag[k][5:0];
        r.score = key[k][SCORE_W-1:0];
        r.match_count = dst[k][CNT_W-1:0];
        r.last = (k == n - 1);
        queue_result(r);
      end
    end
    if (n == 0) begin
      r = blank(KIND_NONE);
      r.last = 1'b1;
      queue_result(r);
    end
  endtask

  task automatic cmp_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, actual %p", $time, got);
      return;
    end
    want = pending_results.pop_front();
    cmp_field("kind", want.kind, got.kind);
    cmp_field("status", want.status, got.status);
    cmp_field("match_isotope", want.match_isotope, got.match_isotope);
    cmp_field("line_energy", want.line_energy, got.line_energy);
    cmp_field("distance", want.distance, got.distance);
    cmp_field("line_intensity", want.line_intensity, got.line_intensity);
    cmp_field("score", want.score, got.score);
    cmp_field("match_count", want.match_count, got.match_count);
    cmp_field("last", want.last, got.last);
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      line_cnt = 0;
      peak_cnt = 0;
      pending_results.delete();
    end else begin
      if (out_strobe) check_result(out_data);
      if (start && !busy) predict_results(in_data);
    end
    pending = pending_results.size();
  end

endmodule

>>> dv/tb.sv
// Testbench top for gamma_line_library_match_core: clock, reset, command stimulus
// and verdict. Depends on gllm_pkg, gllm_checker and the core.
`timescale 1ns / 100ps

module tb;
  import gllm_pkg::*;

  localparam longint CYCLE_LIMIT = 60_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_strobe;
  out_item_t out_data;
  int        errors, pending;
  longint    cycles = 0;
  int        sent = 0;
  bit        no_idle = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gamma_line_library_match_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data)
  );

  gllm_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** gamma_line_library_match_core: FAILED **");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // hold start until the transfer, then idle for a random gap
  task automatic issue(mode_t m, bit clr, logic [5:0] iso, logic [15:0] en,
                       logic [15:0] inten, logic [11:0] w);
    int gap;
    in_data <= '{mode: m, clear_first: clr, isotope_id: iso, energy: en,
                 intensity: inten, width: w};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    gap = idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] near(int c, int spread);
    int e;
    e = c + $urandom_range(0, 2 * spread) - spread;
    if (e < 0) e = 0;
    if (e > 65535) e = 65535;
    return e[15:0];
  endfunction

  task automatic session();
    int c, nl, np, nq, spread;
    c = $urandom_range(0, 65535);
    spread = $urandom_range(0, 3) == 0 ? 4000 : 400;
    if ($urandom_range(0, 2) != 0) begin
      nl = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 10);
      for (int i = 0; i < nl; i++)
        issue(MODE_LIB_WR, i == 0, $urandom_range(0, 63),
              ($urandom_range(0, 4) == 0) ? 16'($urandom) : near(c, spread),
              16'($urandom), 12'($urandom));
    end
    if ($urandom_range(0, 1) != 0) begin
      np = $urandom_range(1, 18);
      for (int i = 0; i < np; i++)
        issue(MODE_PEAK_ADD, i == 0, 6'($urandom), near(c, spread), 16'($urandom),
              12'($urandom));
    end
    nq = $urandom_range(1, 4);
    for (int i = 0; i < nq; i++) begin
      if ($urandom_range(0, 19) == 0)
        issue(mode_t'($urandom_range(0, 3)), 1'($urandom), 6'($urandom), 16'($urandom),
              16'($urandom), 12'($urandom));
      else
        issue(($urandom_range(0, 4) == 0) ? MODE_IDENTIFY : MODE_LINE_MATCH,
              1'($urandom), 6'($urandom), near(c, spread), 16'($urandom),
              ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 120)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stores, then extremes of every field
    issue(MODE_LINE_MATCH, 1'b0, 6'd0, 16'd1000, 16'd0, 12'd0);
    issue(MODE_IDENTIFY, 1'b1, 6'd63, 16'hFFFF, 16'hFFFF, 12'hFFF);
    issue(MODE_LIB_WR, 1'b1, 6'd63, 16'd0, 16'hFFFF, 12'hFFF);
    issue(MODE_LIB_WR, 1'b0, 6'd0, 16'hFFFF, 16'd0, 12'd0);
    issue(MODE_LIB_WR, 1'b0, 6'd5, 16'd1000, 16'd25600, 12'd0);
    issue(MODE_LIB_WR, 1'b0, 6'd5, 16'd1000, 16'd25600, 12'd0);
    issue(MODE_LIB_WR, 1'b0, 6'd42, 16'd1240, 16'd25600, 12'd0);
    issue(MODE_LINE_MATCH, 1'b0, 6'd0, 16'd1000, 16'd0, 12'd0);
    issue(MODE_LINE_MATCH, 1'b0, 6'd0, 16'd1240, 16'd0, 12'd80);
    issue(MODE_LINE_MATCH, 1'b0, 6'd0, 16'hFFFF, 16'd0, 12'hFFF);
    issue(MODE_LINE_MATCH, 1'b0, 6'd0, 16'd0, 16'd0, 12'd1);
    issue(MODE_LINE_MATCH, 1'b0, 6'd0, 16'd30000, 16'd0, 12'd1);
    issue(MODE_IDENTIFY, 1'b0, 6'd0, 16'd0, 16'd0, 12'd0);
    issue(MODE_PEAK_ADD, 1'b1, 6'd0, 16'd1010, 16'd0, 12'd0);
    issue(MODE_PEAK_ADD, 1'b0, 6'd0, 16'd1240, 16'd0, 12'd0);
    issue(MODE_PEAK_ADD, 1'b0, 6'd0, 16'hFFFF, 16'd0, 12'd0);
    issue(MODE_IDENTIFY, 1'b0, 6'd0, 16'd0, 16'd0, 12'd0);
    issue(MODE_IDENTIFY, 1'b0, 6'd0, 16'd0, 16'd0, 12'hFFF);
    // overfill the peak buffer
    no_idle = 1;
    for (int i = 0; i < 15; i++) issue(MODE_PEAK_ADD, 1'b0, 6'd0, 16'(i * 7), 16'd0, 12'd0);
    no_idle = 0;

    while (sent < 420) begin
      no_idle = ($urandom_range(0, 3) == 0);
      session();
    end
    start <= 1'b0;

    // let the checker register the last transfer before looking at the count
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("** gamma_line_library_match_core: PASSED **");
    end else begin
      $display("** gamma_line_library_match_core: FAILED **");
    end
    $finish;
  end

endmodule
